>>> rtl/nearest_request_select_unit_macros.svh
// Assertion macros for the nearest request select unit checker.
// Depends on nothing; included by the checker file.
`ifndef NEAREST_REQUEST_SELECT_UNIT_MACROS_SVH
`define NEAREST_REQUEST_SELECT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define NRS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("nrs check failed");

// Next-cycle implication, disabled while reset is low.
`define NRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("nrs check failed");

`endif

>>> rtl/nrs_pkg.sv
// Shared constants for the nearest request select unit.
// No dependencies; used by the top level and its checker.
`default_nettype none
package nrs_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 1024;
  localparam int unsigned CYL_BITS_DEF    = 10;

  localparam int unsigned FIELD_W   = 10;
  localparam int unsigned ENTRIES_W = 11;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 11'd1000;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [DIR_W-1:0] DIR_ANY   = 2'd0;
  localparam logic [DIR_W-1:0] DIR_BELOW = 2'd1;
  localparam logic [DIR_W-1:0] DIR_ABOVE = 2'd2;

  // register index as seen on paddr[2]
  localparam logic REG_ENTRIES = 1'b0;

endpackage
`default_nettype wire

>>> rtl/nearest_request_select_unit.sv
// Nearest request select unit: request table in one synchronous RAM, scanned per query.
// Write beat: stored in the RAM directly. Query beat: one RAM read per slot for
// min(entries_in_use, TABLE_SLOTS) slots, a drain and a load stage (only the load for
// scan length 0); the load waits for a free output, next beat after. Reset: asynchronous,
// active low; a clearing pass over all TABLE_SLOTS slots empties the table, with
// s_axis_tready low until it ends. APB writes are taken at any time. Depends on nrs_pkg.
`default_nettype none
module nearest_request_select_unit #(
  parameter int unsigned TABLE_SLOTS   = nrs_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned CYLINDER_BITS = nrs_pkg::CYL_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // tdata: slot[9:0], slot_valid[10], cylinder[20:11], head[30:21], direction[32:31]
  input  wire logic [nrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: kind[0]
  input  wire logic                            s_axis_tuser,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: best_slot[9:0], best_distance[19:10]
  output logic [nrs_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // tuser: found[0]
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [nrs_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [nrs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [nrs_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import nrs_pkg::*;

  localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned MEM_W  = CYLINDER_BITS + 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_SLOTS - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [MEM_W-1:0] mem [TABLE_SLOTS];

  logic [2:0]               state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [CNT_W-1:0]         limit_q, limit_d;
  logic [CYLINDER_BITS-1:0] head_q, head_d;
  logic [DIR_W-1:0]         dir_q, dir_d;
  logic                     pend_q, pend_d;
  logic [SLOT_W-1:0]        pend_idx_q, pend_idx_d;
  logic                     have_q, have_d;
  logic [SLOT_W-1:0]        best_slot_q, best_slot_d;
  logic [CYLINDER_BITS-1:0] best_d_q, best_d_d;
  logic [ENTRIES_W-1:0]     entries_q, entries_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_found_q, out_found_d;
  logic [FIELD_W-1:0]       out_slot_q, out_slot_d;
  logic [FIELD_W-1:0]       out_dist_q, out_dist_d;
  logic [MEM_W-1:0]         rdata_q;

  logic                     in_acc;
  logic [FIELD_W-1:0]       f_slot, f_cyl, f_head;
  logic                     f_sval;
  logic [DIR_W-1:0]         f_dir;
  logic [31:0]              slot32, cyl32, head32, lim32, ent32;
  logic                     wr_en, rd_en;
  logic [SLOT_W-1:0]        wr_addr;
  logic [MEM_W-1:0]         wr_data;
  logic [CYLINDER_BITS-1:0] c_val, cyl_gap;
  logic                     c_ok, better;
  logic [31:0]              bs32, bd32;

  assign f_slot = s_axis_tdata[9:0];
  assign f_sval = s_axis_tdata[10];
  assign f_cyl  = s_axis_tdata[20:11];
  assign f_head = s_axis_tdata[30:21];
  assign f_dir  = s_axis_tdata[32:31];

  assign slot32 = {22'd0, f_slot};
  assign cyl32  = {22'd0, f_cyl};
  assign head32 = {22'd0, f_head};
  assign ent32  = {21'd0, entries_q};
  assign lim32  = (ent32 > 32'(TABLE_SLOTS)) ? 32'(TABLE_SLOTS) : ent32;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENTRIES) ? {21'd0, entries_q} : '0;

  assign c_val   = rdata_q[CYLINDER_BITS-1:0];
  assign cyl_gap = (c_val > head_q) ? (c_val - head_q) : (head_q - c_val);
  assign c_ok  = rdata_q[CYLINDER_BITS]
              && !((dir_q == DIR_BELOW) && (c_val > head_q))
              && !((dir_q == DIR_ABOVE) && (c_val < head_q));
  assign better = pend_q && c_ok && (!have_q || (cyl_gap < best_d_q));

  assign bs32 = 32'(best_slot_q);
  assign bd32 = 32'(best_d_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {4'd0, out_dist_q, out_slot_q};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot32[SLOT_W-1:0];
    wr_data = f_sval ? {1'b1, cyl32[CYLINDER_BITS-1:0]} : '0;
    rd_en   = 1'b0;

    state_d     = state_q;
    cnt_d       = cnt_q;
    limit_d     = limit_q;
    head_d      = head_q;
    dir_d       = dir_q;
    pend_d      = 1'b0;
    pend_idx_d  = cnt_q[SLOT_W-1:0];
    have_d      = have_q;
    best_slot_d = best_slot_q;
    best_d_d    = best_d_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_found_d = out_found_q;
    out_slot_d  = out_slot_q;
    out_dist_d  = out_dist_q;
    entries_d   = entries_q;

    if (psel && penable && pwrite && (paddr[2] == REG_ENTRIES)) begin
      entries_d = pwdata[ENTRIES_W-1:0];
    end

    if (better) begin
      have_d      = 1'b1;
      best_slot_d = pend_idx_q;
      best_d_d    = cyl_gap;
    end

    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q[SLOT_W-1:0];
        wr_data = '0;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == LAST_CNT) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == KIND_WRITE) begin
            wr_en = (slot32 < 32'(TABLE_SLOTS));
          end else begin
            head_d  = head32[CYLINDER_BITS-1:0];
            dir_d   = f_dir;
            limit_d = lim32[CNT_W-1:0];
            cnt_d   = '0;
            have_d  = 1'b0;
            state_d = (lim32 == 32'd0) ? ST_FINISH : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en  = 1'b1;
        pend_d = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if ((cnt_q + 1'b1) == limit_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_found_d = have_q;
          out_slot_d  = have_q ? bs32[FIELD_W-1:0] : '0;
          out_dist_d  = have_q ? bd32[FIELD_W-1:0] : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[cnt_q[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      limit_q     <= '0;
      pend_q      <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
      entries_q   <= ENTRIES_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      limit_q     <= limit_d;
      pend_q      <= pend_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
      entries_q   <= entries_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q      <= head_d;
    dir_q       <= dir_d;
    pend_idx_q  <= pend_idx_d;
    best_slot_q <= best_slot_d;
    best_d_q    <= best_d_d;
    out_found_q <= out_found_d;
    out_slot_q  <= out_slot_d;
    out_dist_q  <= out_dist_d;
  end

endmodule
`default_nettype wire

>>> rtl/nrs_checker.sv
// Port-level checks for the nearest request select unit, bound to the top level.
// Depends on nrs_pkg and nearest_request_select_unit_macros.svh.
`default_nettype none
`include "nearest_request_select_unit_macros.svh"
module nrs_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic [nrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input wire logic                            s_axis_tuser,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [nrs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire logic                            m_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready
);
  import nrs_pkg::*;

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  `NRS_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
  `NRS_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_beat && (s_axis_tuser == KIND_QUERY), !s_axis_tready)
  `NRS_ASSERT_NEXT(a_write_silent, clk_i, rst_ni, in_beat && (s_axis_tuser == KIND_WRITE) && !m_axis_tvalid, !m_axis_tvalid)
  `NRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind nearest_request_select_unit nrs_checker u_nrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
`default_nettype wire
